// ===== rtl/prm_pkg.sv =====
// Package for the protected range map: sizes, status and mode codes, the
// entry record and the sequencer state type. No dependencies.
package prm_pkg;
    localparam int MaxRanges = 16;
    localparam int IdxW = $clog2(MaxRanges);
    localparam int CntW = $clog2(MaxRanges + 1);
    localparam int AddrW = 32;
    localparam int EndW = AddrW + 1;
    localparam int EntryW = AddrW + EndW + 3;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_CHECK  = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_BAD  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_COPY,
        S_CHK_SCAN,
        S_FIND_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [AddrW-1:0] start;
        logic [EndW-1:0]  stop;
        logic [2:0]       perm;
    } entry_t;
endpackage

// ===== rtl/prm_ram.sv =====
// Generic single-port write, single-port read RAM with registered read.
// No dependencies.
module prm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/prm_cmp.sv =====
// Shared compare unit: tests one table entry against a span or address.
// Depends on prm_pkg.
module prm_cmp (
    input  prm_pkg::entry_t         ent,
    input  logic                    ent_valid,
    input  logic [prm_pkg::EndW-1:0] lo,
    input  logic [prm_pkg::EndW-1:0] hi,
    output logic                    overlap,
    output logic                    holds_lo,
    output logic                    left_part,
    output logic                    right_part
);
    import prm_pkg::*;
    logic [EndW-1:0] es;

    assign es = {1'b0, ent.start};
    assign overlap    = ent_valid && (es < hi) && (lo < ent.stop);
    assign holds_lo   = ent_valid && (es <= lo) && (lo < ent.stop);
    assign left_part  = es < lo;
    assign right_part = ent.stop > hi;
endmodule

// ===== rtl/protected_range_map_core.sv =====
// Top level of the protected range map: sequencer, entry memories and the
// shared compare unit. Depends on prm_pkg, prm_ram and prm_cmp.
//
// Usage: one request word enters on the s_ channel (mode, span start,
// span size, permissions) and one result word leaves on the m_ channel
// (status, found start, found end, found permissions). The block works on
// one word at a time and deasserts s_axis_tready while it is busy.
// Each pass visits every table slot once through one memory read port and
// one compare unit, one slot per cycle, with registered reads. A find
// makes one pass. An insert writes the new range and scans the live table
// into the scratch bank, then swaps banks in the copy state unless the
// table fills. A coverage check takes one pass per range in the chain, up
// to MaxRanges+1 passes. Bad spans and the unused mode go straight to the
// done state.
// Reset empties the table at once through per-slot valid bits; no clearing
// pass is needed. When the receiver stalls, the result holds on m_axis_tdata;
// one more request may be accepted and processed, and its result waits until
// the held word is taken.
module protected_range_map_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[1:0], span_start[33:2], span_size[65:34], perm_bits[68:66], zero pad
    input  logic [71:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], found_start[33:2], found_end[66:34], found_perm[69:67], pad
    output logic [71:0]  m_axis_tdata
);
    import prm_pkg::*;

    state_t state_reg, state_next;
    logic [EndW-1:0] lo_reg, hi_reg;
    logic [2:0] perm_reg;
    logic [IdxW:0] idx_reg;
    logic [CntW-1:0] n_reg;
    logic [CntW-1:0] steps_reg;
    logic full_reg, hit_reg, sel_reg;
    logic [MaxRanges-1:0] valid_reg;
    status_t st_reg;
    entry_t found_reg;
    logic [71:0] out_reg;
    logic out_valid_reg;

    logic [1:0] in_mode;
    logic [AddrW-1:0] in_start, in_size;
    logic [2:0] in_perm;
    logic [EndW-1:0] in_end;
    assign in_mode  = s_axis_tdata[1:0];
    assign in_start = s_axis_tdata[33:2];
    assign in_size  = s_axis_tdata[65:34];
    assign in_perm  = s_axis_tdata[68:66];
    assign in_end   = {1'b0, in_start} + {1'b0, in_size};

    // Two banks: sel_reg picks the live table; the other is scratch.
    logic we_a, we_b;
    logic [IdxW-1:0] waddr, raddr;
    entry_t wdata, rd_a, rd_b, rd;
    logic [IdxW-1:0] rd_idx_reg;
    logic rd_en_reg;

    prm_ram #(.Width(EntryW), .Depth(MaxRanges)) u_bank_a (
        .aclk(aclk), .we(we_a), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rd_a));
    prm_ram #(.Width(EntryW), .Depth(MaxRanges)) u_bank_b (
        .aclk(aclk), .we(we_b), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rd_b));

    assign rd = sel_reg ? rd_b : rd_a;

    logic cur_valid, ov, holds, lp, rp;
    assign cur_valid = rd_en_reg && valid_reg[rd_idx_reg];
    prm_cmp u_cmp (
        .ent(rd), .ent_valid(cur_valid), .lo(lo_reg), .hi(hi_reg),
        .overlap(ov), .holds_lo(holds), .left_part(lp), .right_part(rp));

    logic scanning;
    assign scanning = (state_reg == S_INS_SCAN) || (state_reg == S_CHK_SCAN)
                   || (state_reg == S_FIND_SCAN);
    assign raddr = idx_reg[IdxW-1:0];
    logic last_rd;
    assign last_rd = rd_en_reg && (rd_idx_reg == IdxW'(MaxRanges - 1));

    // Insert scan writes pieces into the scratch bank; the copy cycle writes a
    // held split piece and, unless the table filled, swaps the banks.
    logic [1:0] npieces;
    logic full_hit;
    entry_t piece0, piece1;
    logic [CntW-1:0] n_after;
    always_comb begin
        npieces = 2'd0;
        piece0 = rd;
        piece1 = rd;
        if (cur_valid) begin
            if (ov) begin
                if (lp && rp) begin
                    npieces = 2'd2;
                    piece0.stop = lo_reg;
                    piece1.start = hi_reg[AddrW-1:0];
                end else if (lp) begin
                    npieces = 2'd1;
                    piece0.stop = lo_reg;
                end else if (rp) begin
                    npieces = 2'd1;
                    piece0.start = hi_reg[AddrW-1:0];
                end
            end else begin
                npieces = 2'd1;
            end
        end
        n_after = n_reg + CntW'(npieces);
        full_hit = (npieces != 2'd0) && (n_after > CntW'(MaxRanges));
    end

    // A split needs two writes; the second is held in pend_reg.
    logic pend_reg;
    entry_t pend_ent_reg;
    logic [IdxW-1:0] pend_addr_reg;

    always_comb begin
        we_a = 1'b0;
        we_b = 1'b0;
        waddr = n_reg[IdxW-1:0];
        wdata = piece0;
        if (state_reg == S_INS_SCAN && !full_reg && !full_hit && npieces != 2'd0) begin
            we_a = sel_reg;
            we_b = !sel_reg;
        end else if (state_reg == S_INS_COPY && !full_reg && pend_reg) begin
            waddr = pend_addr_reg;
            wdata = pend_ent_reg;
            we_a = sel_reg;
            we_b = !sel_reg;
        end else if (state_reg == S_IDLE && s_axis_tvalid && s_axis_tready
                     && in_mode == MODE_INSERT) begin
            wdata.start = in_start;
            wdata.stop = in_end;
            wdata.perm = in_perm;
            waddr = '0;
            we_a = sel_reg;
            we_b = !sel_reg;
        end
    end

    // Check chaining: a hit in this pass moves lo to the range end.
    logic chk_found, hit_now;
    assign chk_found = holds && ((rd.perm & perm_reg) == perm_reg);
    assign hit_now = hit_reg || chk_found;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    if (in_size == '0 || in_end > EndW'(1) << AddrW) begin
                        state_next = S_DONE;
                    end else begin
                        unique case (in_mode)
                            MODE_INSERT: state_next = S_INS_SCAN;
                            MODE_CHECK:  state_next = S_CHK_SCAN;
                            MODE_FIND:   state_next = S_FIND_SCAN;
                            default:     state_next = S_DONE;
                        endcase
                    end
                end
            end
            S_INS_SCAN: begin
                if (last_rd) state_next = S_INS_COPY;
            end
            S_INS_COPY: begin
                state_next = S_DONE;
            end
            S_CHK_SCAN: begin
                if (lo_reg >= hi_reg) begin
                    state_next = S_DONE;
                end else if (last_rd) begin
                    state_next = (hit_now && steps_reg != CntW'(MaxRanges))
                               ? S_CHK_SCAN : S_DONE;
                end
            end
            S_FIND_SCAN: begin
                if (last_rd) state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || m_axis_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            sel_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
            rd_en_reg <= 1'b0;
            pend_reg <= 1'b0;
            full_reg <= 1'b0;
            hit_reg <= 1'b0;
            n_reg <= '0;
            steps_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_axis_tready) out_valid_reg <= 1'b0;
            rd_en_reg <= 1'b0;
            if (state_reg == S_IDLE && s_axis_tvalid && s_axis_tready) begin
                lo_reg <= {1'b0, in_start};
                hi_reg <= in_end;
                perm_reg <= in_perm;
                idx_reg <= '0;
                n_reg <= CntW'(1);
                steps_reg <= '0;
                full_reg <= 1'b0;
                hit_reg <= 1'b0;
                pend_reg <= 1'b0;
                found_reg <= '0;
                st_reg <= ST_MISS;
            end
            if (scanning && state_next != S_DONE && idx_reg != (IdxW+1)'(MaxRanges)) begin
                idx_reg <= idx_reg + 1'b1;
                rd_idx_reg <= idx_reg[IdxW-1:0];
                rd_en_reg <= 1'b1;
            end
            if (state_reg == S_INS_SCAN && rd_en_reg && !full_reg) begin
                if (full_hit) begin
                    full_reg <= 1'b1;
                end else begin
                    n_reg <= n_after;
                    if (npieces == 2'd2) begin
                        pend_reg <= 1'b1;
                        pend_ent_reg <= piece1;
                        pend_addr_reg <= IdxW'(n_reg + 1'b1);
                    end
                end
            end
            if (state_reg == S_INS_COPY) begin
                if (full_reg) begin
                    st_reg <= ST_FULL;
                end else begin
                    st_reg <= ST_OK;
                    sel_reg <= !sel_reg;
                    for (int i = 0; i < MaxRanges; i++)
                        valid_reg[i] <= (CntW'(i) < n_reg);
                end
            end
            if (state_reg == S_CHK_SCAN) begin
                if (chk_found && !hit_reg) begin
                    hit_reg <= 1'b1;
                    lo_reg <= rd.stop;
                end
                if (lo_reg >= hi_reg) st_reg <= ST_OK;
                else if (last_rd) begin
                    if (hit_now && steps_reg != CntW'(MaxRanges)) begin
                        hit_reg <= 1'b0;
                        idx_reg <= '0;
                        steps_reg <= steps_reg + 1'b1;
                    end else begin
                        st_reg <= ST_MISS;
                    end
                end
            end
            if (state_reg == S_FIND_SCAN && rd_en_reg && holds && !hit_reg) begin
                hit_reg <= 1'b1;
                if (rd.stop >= hi_reg && (rd.perm & perm_reg) == perm_reg) begin
                    st_reg <= ST_OK;
                    found_reg <= rd;
                end
            end
            if (state_reg == S_IDLE && s_axis_tvalid && s_axis_tready &&
                (in_size == '0 || in_end > EndW'(1) << AddrW)) begin
                st_reg <= ST_BAD;
            end
            if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready)) begin
                out_valid_reg <= 1'b1;
                out_reg <= {2'b00, found_reg.perm, found_reg.stop, found_reg.start, st_reg};
            end
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_nfit: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= CntW'(MaxRanges)) else $error("scratch count overflow");
endmodule

// ===== verif/protected_range_map_core_tb.sv =====
// Testbench for protected_range_map_core: directed and random insert, check and
// find words against a behavioral range table. Depends on prm_pkg and the RTL.
module protected_range_map_core_tb;
    import prm_pkg::*;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] start;
        logic [31:0] size;
        logic [2:0]  perm;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] fstart;
        logic [32:0] fend;
        logic [2:0]  fperm;
    } rsp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    logic [32:0] tbl_start [MaxRanges];
    logic [32:0] tbl_end [MaxRanges];
    logic [2:0]  tbl_perm [MaxRanges];
    logic        tbl_used [MaxRanges];

    rsp_t expected_rsp[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;
    int burst_left = 0;
    logic [31:0] anchor [8];

    always #5 aclk = ~aclk;

    protected_range_map_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic int slot_holding(logic [32:0] addr);
        for (int i = 0; i < MaxRanges; i++)
            if (tbl_used[i] && tbl_start[i] <= addr && addr < tbl_end[i])
                return i;
        return -1;
    endfunction

    function automatic logic [1:0] apply_insert(logic [32:0] s, logic [32:0] e, logic [2:0] p);
        logic [32:0] ns [MaxRanges];
        logic [32:0] ne [MaxRanges];
        logic [2:0]  np [MaxRanges];
        int n;
        n = 1;
        ns[0] = s; ne[0] = e; np[0] = p;
        for (int i = 0; i < MaxRanges; i++) begin
            if (!tbl_used[i]) continue;
            if (tbl_start[i] < e && s < tbl_end[i]) begin
                if (tbl_start[i] < s) begin
                    if (n >= MaxRanges) return ST_FULL;
                    ns[n] = tbl_start[i]; ne[n] = s; np[n] = tbl_perm[i]; n++;
                end
                if (tbl_end[i] > e) begin
                    if (n >= MaxRanges) return ST_FULL;
                    ns[n] = e; ne[n] = tbl_end[i]; np[n] = tbl_perm[i]; n++;
                end
            end else begin
                if (n >= MaxRanges) return ST_FULL;
                ns[n] = tbl_start[i]; ne[n] = tbl_end[i]; np[n] = tbl_perm[i]; n++;
            end
        end
        for (int i = 0; i < MaxRanges; i++) begin
            tbl_used[i] = (i < n);
            if (i < n) begin
                tbl_start[i] = ns[i]; tbl_end[i] = ne[i]; tbl_perm[i] = np[i];
            end
        end
        return ST_OK;
    endfunction

    function automatic logic [1:0] span_covered(logic [32:0] s, logic [32:0] e, logic [2:0] p);
        logic [32:0] cur;
        int k;
        cur = s;
        for (int steps = 0; steps <= MaxRanges && cur < e; steps++) begin
            k = slot_holding(cur);
            if (k < 0 || (tbl_perm[k] & p) != p) return ST_MISS;
            cur = tbl_end[k];
        end
        return (cur >= e) ? ST_OK : ST_MISS;
    endfunction

    function automatic rsp_t map_result(req_t r);
        rsp_t o;
        logic [32:0] s, e;
        int k;
        o = '{ST_MISS, 32'd0, 33'd0, 3'd0};
        s = {1'b0, r.start};
        e = s + {1'b0, r.size};
        if (r.size == 0 || e > 33'h1_0000_0000) begin
            o.status = ST_BAD;
        end else if (r.mode == MODE_INSERT) begin
            o.status = apply_insert(s, e, r.perm);
        end else if (r.mode == MODE_CHECK) begin
            o.status = span_covered(s, e, r.perm);
        end else if (r.mode == MODE_FIND) begin
            k = slot_holding(s);
            if (k >= 0 && tbl_end[k] >= e && (tbl_perm[k] & r.perm) == r.perm) begin
                o.status = ST_OK;
                o.fstart = tbl_start[k][31:0];
                o.fend = tbl_end[k];
                o.fperm = tbl_perm[k];
            end
        end
        return o;
    endfunction

    task automatic send_word(req_t r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tdata <= {3'd0, r.perm, r.size, r.start, r.mode};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_rsp.push_back(map_result(r));
    endtask

    task automatic send(logic [1:0] m, logic [31:0] st, logic [31:0] sz, logic [2:0] p);
        req_t r;
        r = '{m, st, sz, p};
        send_word(r);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge aclk);
    endtask

    task automatic test_special_spans();
        send(MODE_INSERT, 32'h0, 32'h0, 3'd7);
        send(MODE_CHECK, 32'hFFFF_FFFF, 32'h2, 3'd0);
        send(MODE_FIND, 32'h8000_0000, 32'h8000_0001, 3'd0);
        send(MODE_NONE, 32'h10, 32'h10, 3'd1);
        send(MODE_INSERT, 32'hFFFF_FFFF, 32'h1, 3'd5);
        send(MODE_FIND, 32'hFFFF_FFFF, 32'h1, 3'd5);
        send(MODE_INSERT, 32'h0, 32'hFFFF_FFFF, 3'd7);
        send(MODE_INSERT, 32'h1000, 32'h100, 3'd1);
        send(MODE_CHECK, 32'h0, 32'hFFFF_FFFF, 3'd1);
        send(MODE_CHECK, 32'h0, 32'hFFFF_FFFF, 3'd7);
        send(MODE_FIND, 32'h1080, 32'h10, 3'd0);
        send(MODE_FIND, 32'h1080, 32'h100, 3'd1);
        send(MODE_CHECK, 32'h0, 32'h1, 3'd0);
        send(MODE_INSERT, 32'h0, 32'hFFFF_FFFF, 3'd2);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < MaxRanges + 2; i++)
            send(MODE_INSERT, 32'h100 * i, 32'h80, 3'(i));
        send(MODE_INSERT, 32'h140, 32'h10, 3'd4);
        send(MODE_INSERT, 32'h0, 32'h2000, 3'd3);
        send(MODE_CHECK, 32'h0, 32'h2000, 3'd1);
        wait_drained();
    endtask

    task automatic test_random(int count);
        req_t r;
        int a;
        for (int i = 0; i < 8; i++) anchor[i] = $urandom & 32'hFFFF_F000;
        for (int i = 0; i < count; i++) begin
            a = $urandom_range(0, 7);
            r.mode = ($urandom_range(0, 19) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
            r.perm = 3'($urandom);
            case ($urandom_range(0, 9))
                0: begin
                    r.start = $urandom;
                    r.size = $urandom;
                end
                1: begin
                    r.start = $urandom;
                    r.size = $urandom_range(0, 1) ? 32'd0 : ~r.start + 32'($urandom_range(0, 2));
                end
                default: begin
                    r.start = anchor[a] + $urandom_range(0, 4095);
                    r.size = $urandom_range(1, 4096);
                end
            endcase
            if (i == count / 2) wait_drained();
            send_word(r);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn || $urandom_range(0, 99) < 30 && ($urandom_range(0, 3) != 0))
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        rsp_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[1:0];
            got.fstart = m_axis_tdata[33:2];
            got.fend = m_axis_tdata[66:34];
            got.fperm = m_axis_tdata[69:67];
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
            end else begin
                want = expected_rsp.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %h %h %0d got %0d %h %h %0d",
                            want.status, want.fstart, want.fend, want.fperm,
                            got.status, got.fstart, got.fend, got.fperm);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000 && !timed_out) begin
            timed_out = 1'b1;
            $display("protected_range_map_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < MaxRanges; i++) begin
            tbl_used[i] = 1'b0; tbl_start[i] = '0; tbl_end[i] = '0; tbl_perm[i] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_spans();
        test_table_full();
        test_random(1700);
        wait_drained();
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("protected_range_map_core_tb: done, clean");
        else
            $display("protected_range_map_core_tb: done, errors");
        $finish;
    end
endmodule

// ===== protected_range_map_core.f =====
rtl/prm_pkg.sv
rtl/prm_ram.sv
rtl/prm_cmp.sv
rtl/protected_range_map_core.sv
verif/protected_range_map_core_tb.sv
